// ----- hdl/mt19937_bounded_random_defines.svh -----
// Assertion macros used by the generator's top level.
`ifndef MT19937_BOUNDED_RANDOM_DEFINES_SVH
`define MT19937_BOUNDED_RANDOM_DEFINES_SVH
// Checks that a condition implies a consequence in the same cycle.
`define MTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
// Checks that a condition implies a consequence in the next cycle.
`define MTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`endif

// ----- hdl/mtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 bounded random package
// Constants, types and the tempering function of the generator.
// ----------------------------------------------------------------------------
package mtb_pkg;
	localparam int unsigned TW_N     = 624;
	localparam int unsigned TW_M     = 397;
	localparam int unsigned IDX_W    = 10;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned VALUE_W  = 53;
	localparam int unsigned QUEUE_D  = 2;
	localparam logic [31:0] SEED_RST = 32'd5489;
	localparam logic [31:0] INIT_MUL = 32'h6c078965;
	localparam logic [31:0] MATRIX_A = 32'h9908b0df;
	localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C = 32'hefc60000;

	// Request kinds as classified by the front part.
	typedef enum logic [1:0] {
		REQ_RAW  = 2'd0,
		REQ_ZERO = 2'd1,
		REQ_MOD  = 2'd2,
		REQ_FRAC = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t   kind;
		logic [31:0] limit;
	} req_t;

	// Standard MT19937 output tempering.
	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction
endpackage

// ----- hdl/mtb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mtb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          fraction_mode,
	input  logic [31:0]   limit,
	output logic          req_valid,
	input  logic          req_take,
	output mtb_pkg::req_t req
);
	import mtb_pkg::*;

	req_t        mem_q [QUEUE_D];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	req_t        cls;

	// Classify the incoming request.
	always_comb begin
		cls.limit = limit;
		if (fraction_mode)        cls.kind = REQ_FRAC;
		else if (limit == 32'd0)  cls.kind = REQ_RAW;
		else if (limit == 32'd1)  cls.kind = REQ_ZERO;
		else                      cls.kind = REQ_MOD;
	end

	assign full      = (cnt_q == 2'(QUEUE_D));
	assign req_valid = (cnt_q != 2'd0);
	assign req       = mem_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= cls;
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (req_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(req_take);
		end
	end
endmodule

// ----- hdl/mtb_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 divider
// Radix-2 restoring divider for 32-bit words, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mtb_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);
	import mtb_pkg::*;

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial     = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign quotient  = quo_q;
	assign remainder = rem_q;

	// Shift and subtract one bit each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'd0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ----- hdl/mtb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 back end
// Holds the twister store, seeds and regenerates it, draws words and
// reduces them for each request from the queue.
// ----------------------------------------------------------------------------
module mtb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [31:0]   cfg_seed,
	input  logic          req_valid,
	output logic          req_take,
	input  mtb_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_take,
	output logic [52:0]   res_value,
	output logic          busy
);
	import mtb_pkg::*;

	typedef enum logic [3:0] {
		S_SEED, S_IDLE, S_TW_RD0, S_TW_RD1, S_TW_RD2, S_TW_WR,
		S_DRAW_RD, S_DRAW_WT, S_DRAW_T, S_DIV, S_DIV_WT, S_OUT
	} state_t;

	state_t      state_q;
	logic [31:0] mem [TW_N];
	logic [31:0] rdata_q;
	logic [IDX_W-1:0] rd_addr;
	logic        wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0] wr_data;

	logic [IDX_W-1:0] idx_q, pos_q;
	logic [31:0] prev_q, cur_q, nxt_q, word_q, a_q, bound_q, mulp_q;
	req_t        req_q;
	logic        second_q, bound_pass_q;
	logic        div_start;
	logic        div_done;
	logic [31:0] quo, rem;
	logic [31:0] div_a, div_b;
	logic [31:0] y, twisted;

	// Store: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	assign y       = {cur_q[31], nxt_q[30:0]};
	assign twisted = rdata_q ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);

	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] i, input int unsigned k);
		logic [IDX_W:0] s;
		s = {1'b0, i} + (IDX_W+1)'(k);
		if (s >= (IDX_W+1)'(TW_N)) s = s - (IDX_W+1)'(TW_N);
		return s[IDX_W-1:0];
	endfunction

	// Read address per state.
	always_comb begin
		unique case (state_q)
			S_TW_RD0: rd_addr = idx_q;
			S_TW_RD1: rd_addr = wrap(idx_q, 1);
			S_TW_RD2: rd_addr = wrap(idx_q, TW_M);
			default:  rd_addr = pos_q;
		endcase
	end

	// Writes: seeding and twisting.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = twisted;
		if (state_q == S_SEED) begin
			wr_en   = 1'b1;
			wr_data = (idx_q == '0) ? prev_q : mulp_q + 32'(idx_q);
		end else if (state_q == S_TW_WR) begin
			wr_en = 1'b1;
		end
	end

	// The first divider pass of a request finds the bound, later passes reduce words.
	assign div_a     = bound_pass_q ? word_q : 32'hffffffff;
	assign div_b     = req_q.limit;
	assign req_take  = (state_q == S_IDLE) && req_valid && !cfg_valid;
	assign res_valid = (state_q == S_OUT);
	assign busy      = (state_q != S_IDLE);

	mtb_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done),
		.quotient(quo), .remainder(rem)
	);

	// Sequencer: state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SEED;
			idx_q     <= '0;
			pos_q     <= '0;
			prev_q    <= SEED_RST;
			mulp_q    <= '0;
			div_start <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			div_start <= 1'b0;
			if (cfg_valid && state_q == S_IDLE) begin
				state_q <= S_SEED;
				idx_q   <= '0;
				pos_q   <= '0;
				prev_q  <= cfg_seed;
			end else begin
				unique case (state_q)
					S_SEED: begin
						// Next word from the one just written.
						prev_q <= wr_data;
						mulp_q <= INIT_MUL * (wr_data ^ (wr_data >> 30));
						if (idx_q == IDX_W'(TW_N - 1)) begin
							idx_q   <= '0;
							state_q <= S_IDLE;
						end else idx_q <= idx_q + 1'b1;
					end
					S_IDLE: if (req_take) begin
						req_q    <= req;
						second_q <= 1'b0;
						if (req.kind == REQ_ZERO) begin
							res_value <= '0;
							state_q   <= S_OUT;
						end else if (req.kind == REQ_MOD) begin
							div_start <= 1'b1;
							state_q   <= S_DIV;
							bound_pass_q <= 1'b0;
						end else state_q <= (pos_q == '0) ? S_TW_RD0 : S_DRAW_RD;
					end
					S_DIV: if (div_done) begin
						if (!bound_pass_q) begin
							// floor(2^32/L) from floor((2^32-1)/L).
							bound_q <= (rem == div_b - 32'd1) ? quo + 32'd1 : quo;
							bound_pass_q <= 1'b1;
							state_q <= (pos_q == '0) ? S_TW_RD0 : S_DRAW_RD;
						end else if (quo >= bound_q) begin
							state_q <= (pos_q == '0) ? S_TW_RD0 : S_DRAW_RD;
						end else begin
							res_value <= 53'(rem);
							state_q   <= S_OUT;
						end
					end
					S_TW_RD0: state_q <= S_TW_RD1;
					S_TW_RD1: begin
						cur_q   <= rdata_q;
						state_q <= S_TW_RD2;
					end
					S_TW_RD2: begin
						nxt_q   <= rdata_q;
						state_q <= S_TW_WR;
					end
					S_TW_WR: begin
						if (idx_q == IDX_W'(TW_N - 1)) begin
							idx_q   <= '0;
							state_q <= S_DRAW_RD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_TW_RD0;
						end
					end
					S_DRAW_RD: state_q <= S_DRAW_WT;
					S_DRAW_WT: begin
						word_q  <= temper(rdata_q);
						pos_q   <= wrap(pos_q, 1);
						state_q <= S_DRAW_T;
					end
					S_DRAW_T: begin
						unique case (req_q.kind)
							REQ_RAW: begin
								res_value <= 53'(word_q);
								state_q   <= S_OUT;
							end
							REQ_FRAC: begin
								if (!second_q) begin
									a_q      <= word_q;
									second_q <= 1'b1;
									state_q  <= (pos_q == '0) ? S_TW_RD0 : S_DRAW_RD;
								end else begin
									res_value <= {a_q[31:4], word_q[31:7]};
									state_q   <= S_OUT;
								end
							end
							default: begin
								div_start <= 1'b1;
								state_q   <= S_DIV;
							end
						endcase
					end
					S_OUT: if (res_take) state_q <= S_IDLE;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule

// ----- hdl/mt19937_bounded_random.sv -----
// A limit of one returns zero without drawing a word; a raw word is read and tempered; a fraction
// draws two words; a bounded draw takes two divider passes (bound, then reduction) plus one per rejected word.
// A draw that finds the read position at zero first regenerates the store.
// Throughput: one request at a time in the back end, the next taken the cycle after a result
// is popped; two requests may wait in the front queue.
// Reset and seed writes fill the 624-word store without accepting work.
`timescale 1ns / 1ps
`include "mt19937_bounded_random_defines.svh"
// ----------------------------------------------------------------------------
// MT19937 bounded random generator
// Top level: front request queue, back end generator and result register.
// ----------------------------------------------------------------------------
module mt19937_bounded_random (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        fraction_mode,
	input  logic [31:0] limit,
	output logic        empty,
	input  logic        pop,
	output logic [52:0] value
);
	import mtb_pkg::*;

	logic req_valid, req_take, res_valid, res_take, busy;
	req_t req;

	assign empty     = !res_valid;
	assign res_take  = pop && res_valid;
	assign cfg_ready = !busy && !res_valid && !req_valid;

	mtb_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.fraction_mode(fraction_mode), .limit(limit),
		.req_valid(req_valid), .req_take(req_take), .req(req)
	);

	mtb_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_seed(cfg_data),
		.req_valid(req_valid), .req_take(req_take), .req(req),
		.res_valid(res_valid), .res_take(res_take), .res_value(value),
		.busy(busy)
	);

	// Checks.
	`MTB_ASSERT_IMP(a_no_take_busy, clk, arst_n, busy, !req_take)
	`MTB_ASSERT_IMP(a_take_valid, clk, arst_n, req_take, req_valid)
	`MTB_ASSERT_NXT(a_cfg_seeds, clk, arst_n, cfg_valid && cfg_ready, busy)
endmodule

// ----- tb/tb_mt19937_bounded_random.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 bounded random generator testbench
// Drives integer and fraction requests through the request queue under random
// sender gaps and receiver stalls, with seed changes between phases, and checks
// every value against a built-in model of the twister.
// ----------------------------------------------------------------------------
module tb_mt19937_bounded_random;
	import mtb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        push;
	logic        full;
	logic        fraction_mode;
	logic [31:0] limit;
	logic        empty;
	logic        pop;
	logic [52:0] value;

	// Model state of the twister.
	logic [31:0] mdl_store [TW_N];
	int unsigned mdl_pos;

	// Values still to arrive, oldest first.
	logic [52:0] pending_values [$];
	int unsigned mismatch_count;
	bit          hold_off;
	bit          hold_start;

	// A directed request; want_known marks rows whose value is typed in.
	typedef struct {
		logic        frac;
		logic [31:0] lim;
		bit          want_known;
		logic [52:0] want;
	} request_row_t;

	mt19937_bounded_random u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.fraction_mode (fraction_mode),
		.limit         (limit),
		.empty         (empty),
		.pop           (pop),
		.value         (value)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Overall time limit.
	initial begin
		#200ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Standard initialisation of the store from a seed.
	task automatic seed_store(input logic [31:0] s);
		mdl_store[0] = s;
		for (int i = 1; i < TW_N; i++)
			mdl_store[i] = INIT_MUL * (mdl_store[i-1] ^ (mdl_store[i-1] >> 30))
				+ 32'(i);
		mdl_pos = 0;
	endtask

	// Next tempered word, regenerating the store when the position wraps.
	function automatic logic [31:0] next_word();
		logic [31:0] y;
		int unsigned nx, fr;
		if (mdl_pos == 0) begin
			for (int unsigned i = 0; i < TW_N; i++) begin
				nx = (i != TW_N - 1) ? i + 1 : 0;
				fr = (i >= 227) ? i - 227 : i + TW_M;
				y = (mdl_store[i] & 32'h8000_0000) | (mdl_store[nx] & 32'h7fff_ffff);
				mdl_store[i] = mdl_store[fr] ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'h0);
			end
		end
		y = mdl_store[mdl_pos];
		mdl_pos = (mdl_pos == TW_N - 1) ? 0 : mdl_pos + 1;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// Value the generator should return for one request.
	function automatic logic [52:0] draw_value(input logic frac, input logic [31:0] lim);
		logic [31:0] a, b, w, bound;
		if (frac) begin
			a = next_word();
			b = next_word();
			return ({21'd0, a >> 4} << 25) | 53'(b >> 7);
		end
		if (lim == 0)
			return 53'(next_word());
		if (lim == 1)
			return '0;
		bound = 32'(64'h1_0000_0000 / 64'(lim));
		do
			w = next_word();
		while ((w / lim) >= bound);
		return 53'(w % lim);
	endfunction

	// One request transaction; the predicted value is queued on acceptance.
	task automatic send_request(input request_row_t r);
		logic [52:0] v;
		fraction_mode <= r.frac;
		limit         <= r.lim;
		push          <= 1'b1;
		do
			@(posedge clk);
		while (full);
		v = draw_value(r.frac, r.lim);
		if (r.want_known && v !== r.want)
			report_mismatch($sformatf("model disagrees with row: %h", v));
		pending_values.push_back(r.want_known ? r.want : v);
		@(negedge clk);
		push <= 1'b0;
	endtask

	// Waits for the queue to drain, then rewrites the seed.
	task automatic write_seed(input logic [31:0] s);
		int unsigned n;
		n = 0;
		while (pending_values.size() != 0 && n < 100000) begin
			@(negedge clk);
			n++;
		end
		repeat (50) @(negedge clk);
		cfg_data  <= s;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		seed_store(s);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random request: small limits, some extremes, fully random limits and some fractions.
	function automatic request_row_t random_row();
		request_row_t r;
		r.want_known = 0;
		r.want = '0;
		r.frac = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 5))
			0: r.lim = $urandom_range(0, 1);
			1: r.lim = $urandom_range(2, 20);
			2: r.lim = 32'h8000_0000 + $urandom_range(0, 1000);
			3: r.lim = 32'hffff_ffff - $urandom_range(0, 3);
			default: r.lim = $urandom;
		endcase
		return r;
	endfunction

	// Receiver hold-off: one long stretch, timed in cycles, so the block fills up.
	initial begin
		hold_off = 1'b0;
		wait (hold_start);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (6000) @(negedge clk);
		hold_off = 1'b0;
	end

	// Receiver: pops on its own stall pattern, with one long hold-off.
	always @(negedge clk) begin
		if (!arst_n || hold_off)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(0, 3) != 0);
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_values.size() == 0)
				report_mismatch($sformatf("unexpected value %h", value));
			else if (value !== pending_values[0])
				report_mismatch($sformatf("value %h, expected %h", value,
					pending_values.pop_front()));
			else
				void'(pending_values.pop_front());
		end
	end

	// Stimulus.
	initial begin
		request_row_t rows [$];
		request_row_t r;
		int unsigned wait_cycles;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		push          = 1'b0;
		fraction_mode = 1'b0;
		limit         = '0;
		pop           = 1'b0;
		hold_start    = 1'b0;
		mismatch_count = 0;
		seed_store(SEED_RST);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed table: first raw word after the default seed is well known.
		rows = '{
			'{1'b0, 32'd0, 1, 53'd3499211612},
			'{1'b0, 32'd1, 1, 53'd0},
			'{1'b0, 32'd0, 1, 53'd581869302},
			'{1'b0, 32'd2, 0, 0}, '{1'b0, 32'd3, 0, 0},
			'{1'b0, 32'd7, 0, 0}, '{1'b0, 32'h8000_0000, 0, 0},
			'{1'b0, 32'h8000_0001, 0, 0}, '{1'b0, 32'hffff_ffff, 0, 0},
			'{1'b0, 32'hffff_fffe, 0, 0}, '{1'b0, 32'h5555_5555, 0, 0},
			'{1'b0, 32'haaaa_aaaa, 0, 0}, '{1'b1, 32'd0, 0, 0},
			'{1'b1, 32'hffff_ffff, 0, 0}, '{1'b1, 32'd1, 0, 0},
			'{1'b0, 32'd1, 1, 53'd0}, '{1'b0, 32'd0, 0, 0}
		};
		foreach (rows[i]) begin
			@(negedge clk);
			send_request(rows[i]);
		end

		// Seed extremes, then random phases with bursts and gaps.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_seed(32'd0);
				1: write_seed(32'hffff_ffff);
				2: write_seed($urandom);
				3: write_seed(SEED_RST);
				default: write_seed($urandom);
			endcase
			for (int k = 0; k < 130; ) begin
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0)
					@(negedge clk);
				for (int b = $urandom_range(1, 12); b > 0 && k < 130; b--, k++) begin
					if (ph == 2 && k == 10) hold_start = 1'b1;
					@(negedge clk);
					r = random_row();
					send_request(r);
				end
			end
		end

		// Drain, then allow for a trailing result.
		wait_cycles = 0;
		while (pending_values.size() != 0 && wait_cycles < 2000000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (200) @(negedge clk);
		if (mismatch_count == 0 && pending_values.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
